// ===== rtl/core/rrr_pkg.sv =====
// ----------------------------------------------------------------------------
// rrr_pkg: shared types and helpers for the ray reflect/refract unit
// fixed-point widths, opcodes and the per-stage payload structs
// ----------------------------------------------------------------------------
package rrr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CW        = 16;                // component width
  localparam int DOT_W     = 35;                // sum of three 16x16 products
  localparam int RAD_W     = 2 * FRAC_BITS + 2; // radicand width (<= 2^28)
  localparam int ROOT_W    = RAD_W / 2;         // isqrt result width
  localparam int SQ_STEPS  = ROOT_W;            // one result bit per stage

  typedef enum logic {
    OP_REFLECT = 1'b0,
    OP_REFRACT = 1'b1
  } op_t;

  typedef logic signed [CW-1:0] comp_t;

  // round half toward +inf then arithmetic shift right by FRAC_BITS
  function automatic logic signed [63:0] rnd_f(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + (64'sd1 <<< (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] rnd_2f(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + (64'sd1 <<< (2 * FRAC_BITS - 1));
    return t >>> (2 * FRAC_BITS);
  endfunction

  // clip to the 16-bit signed range; returns saturation in bit 16
  function automatic logic [CW:0] clip_f(input logic signed [63:0] v);
    if (v > 64'sd32767) return {1'b1, 16'sh7fff};
    if (v < -64'sd32768) return {1'b1, 16'sh8000};
    return {1'b0, v[CW-1:0]};
  endfunction

  typedef struct packed {
    logic  vld;
    op_t   op;
    comp_t dx, dy, dz, nx, ny, nz;
    logic [CW-1:0] eta;
  } in_bus_t;

endpackage

// ===== rtl/core/ray_reflect_refract_top.sv =====
// ----------------------------------------------------------------------------
// ray_reflect_refract_top: mirror reflection and snell refraction unit
// stream in a direction and normal, stream out the bent direction
// ----------------------------------------------------------------------------
// usage
//   in channel carries one ray hit per item: opcode in tuser, direction,
//   normal and index ratio in tdata. out channel returns one item per input:
//   resulting direction in tdata, invalid and saturated flags in tuser.
//   reflect gives d - 2(d.n)n; refract follows snell's law and flags total
//   internal reflection with a zero vector.
// depth and throughput
//   7 front, 15 square root and 2 back stages from input accept to output
//   valid; one item per cycle sustained while the output is not stalled.
//   the square root pipeline, one result bit per stage, sets the depth.
// reset
//   rst_n low clears every valid bit; no item is in flight afterwards.
// stall
//   the whole pipeline advances only when the output register is empty or
//   being taken, so a stalled receiver freezes every stage; nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
module ray_reflect_refract_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [111:0]  in_tdata,   // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio
  input  logic [0:0]    in_tuser,   // opcode
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata,  // out_x, out_y, out_z
  output logic [1:0]    out_tuser   // invalid, saturated
);
  import rrr_pkg::*;

  logic    en;
  in_bus_t in_bus;

  logic        f_vld, f_op, f_sat, f_neg;
  logic signed [15:0] f_nx, f_ny, f_nz, f_px, f_py, f_pz;
  logic [29:0] f_rad;
  logic        s_vld;
  logic [14:0] s_root;
  logic [99:0] s_side;
  logic [49:0] res;

  // global enable: advance when the output slot is free or leaving
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    in_bus.vld = in_tvalid && en;
    in_bus.op  = op_t'(in_tuser[0]);
    in_bus.dx  = in_tdata[15:0];
    in_bus.dy  = in_tdata[31:16];
    in_bus.dz  = in_tdata[47:32];
    in_bus.nx  = in_tdata[63:48];
    in_bus.ny  = in_tdata[79:64];
    in_bus.nz  = in_tdata[95:80];
    in_bus.eta = in_tdata[111:96];
  end

  rrr_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_bus(in_bus),
    .vld_o(f_vld), .op_o(f_op),
    .nx_o(f_nx), .ny_o(f_ny), .nz_o(f_nz),
    .px_o(f_px), .py_o(f_py), .pz_o(f_pz),
    .sat_o(f_sat), .rad_o(f_rad), .neg_o(f_neg)
  );

  rrr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(f_vld), .rad_i(f_rad),
    .side_i({1'b0, f_op, f_neg, f_sat, f_nx, f_ny, f_nz, f_px, f_py, f_pz}),
    .vld_o(s_vld), .root_o(s_root), .side_o(s_side)
  );

  rrr_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(s_vld), .root_i(s_root),
    .side_i(s_side), .vld_o(out_tvalid), .res_o(res)
  );

  assign out_tdata = res[47:0];
  assign out_tuser = res[49:48];

  // invalid only ever comes with a zero vector and no saturation
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 48'd0 && !out_tuser[1])
    else $error("invalid result not zeroed");

  // pipeline frozen while the receiver stalls
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result changed");

  // no input taken while the output register stalls
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted during stall");

endmodule

// ===== rtl/core/rrr_front.sv =====
// ----------------------------------------------------------------------------
// rrr_front: dot product, cosine clamp, perpendicular term and reflect result
// seven register stages, each holding about one multiply or add level
// ----------------------------------------------------------------------------
module rrr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  rrr_pkg::in_bus_t in_bus,
  output logic             vld_o,
  output logic             op_o,
  output logic signed [15:0] nx_o, ny_o, nz_o,
  output logic signed [15:0] px_o, py_o, pz_o,   // perp (refract) or result (reflect)
  output logic             sat_o,
  output logic [29:0]      rad_o,                // 2^28 - |perp|^2, clipped at 0
  output logic             neg_o
);
  import rrr_pkg::*;

  // stage 1: products d_i*n_i
  logic v1_r;
  in_bus_t b1_r;
  logic signed [31:0] m0_r, m1_r, m2_r;
  // stage 2: dot and clamped cosine
  logic v2_r;
  in_bus_t b2_r;
  logic signed [DOT_W-1:0] dot_r, cos_r;
  // stage 3: scaled normal products
  logic v3_r;
  in_bus_t b3_r;
  logic signed [51:0] tx_r, ty_r, tz_r;
  // stage 4: reflect result or s = d + round(c*n)
  logic v4_r;
  in_bus_t b4_r;
  logic signed [19:0] sx_r, sy_r, sz_r;
  logic signed [15:0] rx_r, ry_r, rz_r;
  logic rsat_r;
  // stage 5: perp = clip(round(eta*s)) for refract, the reflect result for reflect
  logic v5_r;
  in_bus_t b5_r;
  logic signed [15:0] p5x_r, p5y_r, p5z_r;
  logic s5_r;
  // stage 6: squares
  logic v6_r;
  in_bus_t b6_r;
  logic signed [15:0] p6x_r, p6y_r, p6z_r;
  logic s6_r;
  logic [31:0] q0_r, q1_r, q2_r;
  // stage 7: radicand
  logic v7_r;
  logic op7_r;
  logic signed [15:0] n7x_r, n7y_r, n7z_r, p7x_r, p7y_r, p7z_r;
  logic s7_r, neg7_r;
  logic [29:0] rad7_r;

  logic signed [DOT_W-1:0] dot_nxt, cos_nxt;
  logic signed [63:0] ex, ey, ez, cx, cy, cz, fx, fy, fz;
  logic [CW:0] kx, ky, kz, gx, gy, gz;
  logic signed [35:0] lsq;
  logic signed [36:0] radw;

  always_comb begin
    dot_nxt = DOT_W'(m0_r) + DOT_W'(m1_r) + DOT_W'(m2_r);
    cos_nxt = -dot_nxt;
    if (cos_nxt > (DOT_W'(1) <<< (2 * FRAC_BITS))) cos_nxt = DOT_W'(1) <<< (2 * FRAC_BITS);
    // reflect: d - round(2*dot*n)
    ex = 64'(b3_r.dx) - rnd_2f(64'(tx_r));
    ey = 64'(b3_r.dy) - rnd_2f(64'(ty_r));
    ez = 64'(b3_r.dz) - rnd_2f(64'(tz_r));
    kx = clip_f(ex); ky = clip_f(ey); kz = clip_f(ez);
    cx = 64'(b3_r.dx) + rnd_2f(64'(tx_r));
    cy = 64'(b3_r.dy) + rnd_2f(64'(ty_r));
    cz = 64'(b3_r.dz) + rnd_2f(64'(tz_r));
    fx = rnd_f(64'($signed({1'b0, b4_r.eta})) * 64'(sx_r));
    fy = rnd_f(64'($signed({1'b0, b4_r.eta})) * 64'(sy_r));
    fz = rnd_f(64'($signed({1'b0, b4_r.eta})) * 64'(sz_r));
    gx = clip_f(fx); gy = clip_f(fy); gz = clip_f(fz);
    lsq  = 36'(q0_r) + 36'(q1_r) + 36'(q2_r);
    radw = (37'sd1 <<< (2 * FRAC_BITS)) - 37'(lsq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_bus.vld; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r; v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_r <= in_bus;
      m0_r <= in_bus.dx * in_bus.nx;
      m1_r <= in_bus.dy * in_bus.ny;
      m2_r <= in_bus.dz * in_bus.nz;
      b2_r <= b1_r;
      dot_r <= dot_nxt;
      cos_r <= cos_nxt;
      b3_r <= b2_r;
      // reflect uses 2*dot, refract uses clamped cosine
      if (b2_r.op == OP_REFLECT) begin
        tx_r <= 52'(dot_r <<< 1) * 52'(b2_r.nx);
        ty_r <= 52'(dot_r <<< 1) * 52'(b2_r.ny);
        tz_r <= 52'(dot_r <<< 1) * 52'(b2_r.nz);
      end else begin
        tx_r <= 52'(cos_r) * 52'(b2_r.nx);
        ty_r <= 52'(cos_r) * 52'(b2_r.ny);
        tz_r <= 52'(cos_r) * 52'(b2_r.nz);
      end
      b4_r <= b3_r;
      sx_r <= cx[19:0]; sy_r <= cy[19:0]; sz_r <= cz[19:0];
      rx_r <= kx[15:0]; ry_r <= ky[15:0]; rz_r <= kz[15:0];
      rsat_r <= kx[16] | ky[16] | kz[16];
      b5_r <= b4_r;
      if (b4_r.op == OP_REFLECT) begin
        p5x_r <= rx_r; p5y_r <= ry_r; p5z_r <= rz_r; s5_r <= rsat_r;
      end else begin
        p5x_r <= gx[15:0]; p5y_r <= gy[15:0]; p5z_r <= gz[15:0];
        s5_r <= gx[16] | gy[16] | gz[16];
      end
      b6_r <= b5_r;
      p6x_r <= p5x_r; p6y_r <= p5y_r; p6z_r <= p5z_r; s6_r <= s5_r;
      q0_r <= p5x_r * p5x_r;
      q1_r <= p5y_r * p5y_r;
      q2_r <= p5z_r * p5z_r;
      op7_r <= b6_r.op;
      n7x_r <= b6_r.nx; n7y_r <= b6_r.ny; n7z_r <= b6_r.nz;
      p7x_r <= p6x_r; p7y_r <= p6y_r; p7z_r <= p6z_r; s7_r <= s6_r;
      neg7_r <= radw[36];
      rad7_r <= radw[36] ? 30'd0 : radw[29:0];
    end
  end

  assign vld_o = v7_r;
  assign op_o  = op7_r;
  assign nx_o = n7x_r; assign ny_o = n7y_r; assign nz_o = n7z_r;
  assign px_o = p7x_r; assign py_o = p7y_r; assign pz_o = p7z_r;
  assign sat_o = s7_r;
  assign rad_o = rad7_r;
  assign neg_o = neg7_r;
endmodule

// ===== rtl/core/rrr_sqrt.sv =====
// ----------------------------------------------------------------------------
// rrr_sqrt: pipelined integer square root, one result bit per stage
// carries the side payload alongside the partial remainder
// ----------------------------------------------------------------------------
module rrr_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [29:0] rad_i,
  input  logic [99:0] side_i,
  output logic        vld_o,
  output logic [14:0] root_o,
  output logic [99:0] side_o
);
  import rrr_pkg::*;

  logic [SQ_STEPS:1]        v_r;
  logic [RAD_W-1:0]         rem_r  [1:SQ_STEPS];
  logic [RAD_W-1:0]         val_r  [1:SQ_STEPS];
  logic [ROOT_W-1:0]        root_r [1:SQ_STEPS];
  logic [99:0]              side_r [1:SQ_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQ_STEPS; k++) begin : g_st
      logic [RAD_W-1:0] rem_in, val_in;
      logic [ROOT_W-1:0] root_in;
      logic [99:0] side_in;
      logic v_in;
      logic [RAD_W+1:0] rem2, trial;
      logic [RAD_W-1:0] rem_nxt;
      logic [ROOT_W-1:0] root_nxt;
      if (k == 0) begin : g_first
        assign rem_in  = '0;
        assign val_in  = rad_i;
        assign root_in = '0;
        assign side_in = side_i;
        assign v_in    = vld_i;
      end else begin : g_next
        assign rem_in  = rem_r[k];
        assign val_in  = val_r[k];
        assign root_in = root_r[k];
        assign side_in = side_r[k];
        assign v_in    = v_r[k];
      end
      always_comb begin
        rem2  = {rem_in, val_in[RAD_W-1 -: 2]};
        trial = {root_in, 2'b01};
        if (rem2 >= trial) begin
          rem_nxt  = RAD_W'(rem2 - trial);
          root_nxt = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = RAD_W'(rem2);
          root_nxt = {root_in[ROOT_W-2:0], 1'b0};
        end
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k+1] <= 1'b0;
        end else if (en) begin
          v_r[k+1] <= v_in;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1]  <= rem_nxt;
          val_r[k+1]  <= {val_in[RAD_W-3:0], 2'b00};
          root_r[k+1] <= root_nxt;
          side_r[k+1] <= side_in;
        end
      end
    end
  endgenerate

  assign vld_o  = v_r[SQ_STEPS];
  assign root_o = root_r[SQ_STEPS];
  assign side_o = side_r[SQ_STEPS];
endmodule

// ===== rtl/core/rrr_back.sv =====
// ----------------------------------------------------------------------------
// rrr_back: scales the normal by the root and forms the refracted result
// two register stages: products, then subtract and clip
// ----------------------------------------------------------------------------
module rrr_back (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        vld_i,
  input  logic [14:0] root_i,
  input  logic [99:0] side_i,
  output logic        vld_o,
  output logic [49:0] res_o   // x, y, z, invalid, saturated from low bits
);
  import rrr_pkg::*;

  // side: op, neg, sat, nx, ny, nz, px, py, pz
  logic        op_i, neg_i, sat_i;
  logic signed [15:0] nx_i, ny_i, nz_i, px_i, py_i, pz_i;
  assign {op_i, neg_i, sat_i, nx_i, ny_i, nz_i, px_i, py_i, pz_i} = side_i[98:0];

  logic v1_r, v2_r;
  logic op1_r, neg1_r, sat1_r;
  logic signed [15:0] p1x_r, p1y_r, p1z_r;
  logic signed [31:0] t1x_r, t1y_r, t1z_r;
  logic [49:0] res_r;
  logic [CW:0] kx, ky, kz;
  logic [49:0] res_nxt;

  always_comb begin
    kx = clip_f(64'(p1x_r) - rnd_f(64'(t1x_r)));
    ky = clip_f(64'(p1y_r) - rnd_f(64'(t1y_r)));
    kz = clip_f(64'(p1z_r) - rnd_f(64'(t1z_r)));
    if (op1_r == OP_REFLECT)
      res_nxt = {sat1_r, 1'b0, p1z_r, p1y_r, p1x_r};
    else if (neg1_r)
      res_nxt = {1'b0, 1'b1, 48'd0};
    else
      res_nxt = {kx[16] | ky[16] | kz[16] | sat1_r, 1'b0, kz[15:0], ky[15:0], kx[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i; v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= op_i; neg1_r <= neg_i; sat1_r <= sat_i;
      p1x_r <= px_i; p1y_r <= py_i; p1z_r <= pz_i;
      t1x_r <= $signed({1'b0, root_i}) * nx_i;
      t1y_r <= $signed({1'b0, root_i}) * ny_i;
      t1z_r <= $signed({1'b0, root_i}) * nz_i;
      res_r <= res_nxt;
    end
  end

  assign vld_o = v2_r;
  assign res_o = res_r;
endmodule
